### rtl/pfwl_pkg.sv
package pfwl_pkg;

  // Fixed field widths of the request and register words.
  localparam int unsigned FlowW    = 10;
  localparam int unsigned TicksW   = 32;
  localparam int unsigned MaxReqW  = 16;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 1;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegMaxRequests  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegWindowLength = 1'b1;

  // Register values after reset.
  localparam logic [MaxReqW-1:0] MaxRequestsRst  = 16'd5;
  localparam logic [TicksW-1:0]  WindowLengthRst = 32'd10;

endpackage

### rtl/per_flow_fixed_window_limiter.sv
// Per-flow fixed-window rate limiter. Each request word carries a flow index and
// a timestamp; the block answers with one result word, allowed or blocked. A flow
// opens a new window (count one, allowed) when it has no entry yet or when its
// window began at least window_length ticks ago, counted modulo 2^32; inside a
// window requests are allowed until the count reaches max_requests. Flow indexes
// at or above NUM_FLOWS fold onto an entry by modulo. Per-flow state sits in a
// single-port-read, single-port-write RAM with a registered read. At accept the
// quotient of the flow index is registered; the reduce state forms the remainder
// and reads the RAM; the update state writes the entry back and loads the result
// register, and waits while an earlier result has not been taken; a new request
// is taken only after it. After reset a clearing pass marks every entry empty; no
// request is taken during it, while configuration writes are taken at any time.
module per_flow_fixed_window_limiter #(
  parameter int unsigned NUM_FLOWS  = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfwl_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pfwl_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pfwl_pkg::FlowW-1:0]          flow_id_i,
  input  logic [pfwl_pkg::TicksW-1:0]         now_ticks_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                allowed_o
);

  localparam int unsigned IdxW   = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int unsigned EntryW = 1 + COUNT_BITS + pfwl_pkg::TicksW;
  // Reciprocal for flow_id / NUM_FLOWS, exact for every flow_id below 2^FlowW.
  localparam int unsigned DivS   = pfwl_pkg::FlowW + IdxW;
  localparam int unsigned DivM   = ((2 ** DivS) + NUM_FLOWS - 1) / NUM_FLOWS;
  localparam int unsigned RecipW = pfwl_pkg::FlowW + 1;
  localparam int unsigned ProdW  = pfwl_pkg::FlowW + RecipW;
  localparam logic [RecipW-1:0]     Recip    = RecipW'(DivM);
  localparam logic [IdxW-1:0]       LastIdx  = IdxW'(NUM_FLOWS - 1);
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_UPDATE
  } state_e;

  state_e                          state_q;
  logic [IdxW-1:0]                 clr_q;
  logic [pfwl_pkg::FlowW-1:0]      flow_q;
  logic [pfwl_pkg::FlowW-1:0]      quot_q;
  logic [pfwl_pkg::TicksW-1:0]     now_q;
  logic [IdxW-1:0]                 addr_q;
  logic                            out_valid_q;
  logic                            allowed_q;
  logic [pfwl_pkg::MaxReqW-1:0]    max_req_q;
  logic [pfwl_pkg::TicksW-1:0]     win_len_q;

  logic [ProdW-1:0]                prod;
  logic [pfwl_pkg::FlowW-1:0]      quot;
  logic [pfwl_pkg::FlowW-1:0]      rem;
  logic [IdxW-1:0]                 rd_addr;
  logic [EntryW-1:0]               rd_data;
  logic                            ent_valid;
  logic [COUNT_BITS-1:0]           ent_count;
  logic [pfwl_pkg::TicksW-1:0]     ent_start;
  logic [pfwl_pkg::TicksW-1:0]     elapsed;
  logic                            new_window;
  logic                            can_count;
  logic                            upd_go;
  logic                            upd_ok;
  logic                            upd_wr;
  logic [EntryW-1:0]               upd_data;
  logic                            wr_en;
  logic [IdxW-1:0]                 wr_addr;
  logic [EntryW-1:0]               wr_data;

  // Flow index folding: quotient by reciprocal at accept, remainder next cycle.
  assign prod    = ProdW'(flow_id_i) * ProdW'(Recip);
  assign quot    = pfwl_pkg::FlowW'(prod >> DivS);
  assign rem     = flow_q - pfwl_pkg::FlowW'(quot_q * NUM_FLOWS);
  assign rd_addr = IdxW'({{IdxW{1'b0}}, rem});

  assign ent_valid = rd_data[EntryW-1];
  assign ent_count = rd_data[pfwl_pkg::TicksW +: COUNT_BITS];
  assign ent_start = rd_data[pfwl_pkg::TicksW-1:0];
  assign elapsed   = now_q - ent_start;

  assign new_window = !ent_valid || (elapsed >= win_len_q);
  assign can_count  = (32'(ent_count) < 32'(max_req_q)) && (ent_count != CountMax);

  always_comb begin
    upd_ok   = 1'b0;
    upd_wr   = 1'b0;
    upd_data = {1'b1, CountOne, now_q};
    priority if (new_window) begin
      upd_ok = 1'b1;
      upd_wr = 1'b1;
    end else if (can_count) begin
      upd_ok   = 1'b1;
      upd_wr   = 1'b1;
      upd_data = {1'b1, ent_count + CountOne, ent_start};
    end else begin
      upd_ok = 1'b0;
      upd_wr = 1'b0;
    end
  end

  assign upd_go = (state_q == ST_UPDATE) && (!out_valid_q || out_ready_i);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = upd_data;
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else if (upd_go) begin
      wr_en = upd_wr;
    end
  end

  pfwl_entry_ram #(
    .Depth (NUM_FLOWS),
    .AddrW (IdxW),
    .DataW (EntryW)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .rd_en_i   (state_q == ST_REDUCE),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q <= pfwl_pkg::MaxRequestsRst;
      win_len_q <= pfwl_pkg::WindowLengthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfwl_pkg::RegMaxRequests:  max_req_q <= cfg_data_i[pfwl_pkg::MaxReqW-1:0];
        pfwl_pkg::RegWindowLength: win_len_q <= cfg_data_i[pfwl_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      flow_q      <= '0;
      quot_q      <= '0;
      now_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
      allowed_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !upd_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + IdxW'(1);
          if (clr_q == LastIdx) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            flow_q  <= flow_id_i;
            quot_q  <= quot;
            now_q   <= now_ticks_i;
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          addr_q  <= rd_addr;
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (upd_go) begin
            out_valid_q <= 1'b1;
            allowed_q   <= upd_ok;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign allowed_o   = allowed_q;

endmodule

### rtl/pfwl_entry_ram.sv
module pfwl_entry_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 49
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read, so a stalled update sees it unchanged.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### bench/tb.sv
module tb;

  localparam int unsigned NumFlows  = 1024;
  localparam int unsigned CountBits = 16;
  localparam logic [CountBits-1:0] CountTop = '1;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldCycles = 100;
  localparam int unsigned PhaseItems = 150;

  typedef struct packed {
    logic [pfwl_pkg::MaxReqW-1:0] max_req;
    logic [pfwl_pkg::TicksW-1:0]  win;
    logic [pfwl_pkg::FlowW-1:0]   flow;
    logic [pfwl_pkg::TicksW-1:0]  ticks;
    bit                           typed;
    bit                           verdict;
  } dir_row_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [pfwl_pkg::CfgIdxW-1:0]  cfg_idx_i   = pfwl_pkg::RegMaxRequests;
  logic [pfwl_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [pfwl_pkg::FlowW-1:0]    flow_id_i   = '0;
  logic [pfwl_pkg::TicksW-1:0]   now_ticks_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          allowed_o;

  // Shadow of the per-flow table and the two registers.
  bit                           flow_live  [NumFlows];
  logic [CountBits-1:0]         flow_count [NumFlows];
  logic [pfwl_pkg::TicksW-1:0]  flow_start [NumFlows];
  logic [pfwl_pkg::MaxReqW-1:0] lim_max = pfwl_pkg::MaxRequestsRst;
  logic [pfwl_pkg::TicksW-1:0]  lim_win = pfwl_pkg::WindowLengthRst;

  bit pending_verdicts [$];
  int n_sent       = 0;
  int n_checked    = 0;
  int n_blocked    = 0;
  int n_bad        = 0;
  int n_settings   = 1;
  bit quiet        = 1'b0;
  bit hold_req     = 1'b0;
  int hold_left    = 0;
  int stall_left   = 0;
  int unsigned cyc = 0;
  int unsigned idle_cycles = 0;

  dir_row_t dir_rows [24] = '{
    '{16'd5, 32'd10, 10'd0, 32'd0, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'd0, 32'd1, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'd0, 32'd2, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'd0, 32'd3, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'd0, 32'd4, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'd0, 32'd5, 1'b1, 1'b0},
    '{16'd5, 32'd10, 10'd0, 32'd9, 1'b1, 1'b0},
    '{16'd5, 32'd10, 10'd0, 32'd10, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'd1023, 32'hFFFF_FFFF, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'd1023, 32'h0000_0003, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'd1023, 32'h0000_0008, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'd1023, 32'h0000_0009, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'h2AA, 32'hAAAA_AAAA, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'h155, 32'h5555_5555, 1'b1, 1'b1},
    '{16'd5, 32'd10, 10'h2AA, 32'h5555_5555, 1'b0, 1'b0},
    '{16'd5, 32'd10, 10'd0, 32'd11, 1'b0, 1'b0},
    '{16'd0, 32'hFFFF_FFFF, 10'd5, 32'd100, 1'b1, 1'b1},
    '{16'd0, 32'hFFFF_FFFF, 10'd5, 32'd101, 1'b1, 1'b0},
    '{16'd0, 32'hFFFF_FFFF, 10'd5, 32'd99, 1'b1, 1'b1},
    '{16'hFFFF, 32'd0, 10'd5, 32'd99, 1'b1, 1'b1},
    '{16'hFFFF, 32'd0, 10'd5, 32'd99, 1'b1, 1'b1},
    '{16'd1, 32'd1, 10'd7, 32'd0, 1'b1, 1'b1},
    '{16'd1, 32'd1, 10'd7, 32'd0, 1'b1, 1'b0},
    '{16'd1, 32'd1, 10'd7, 32'd1, 1'b1, 1'b1}
  };

  per_flow_fixed_window_limiter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .flow_id_i  (flow_id_i),
    .now_ticks_i(now_ticks_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .allowed_o  (allowed_o)
  );

  always #6 clk_i = ~clk_i;

  // Decides one request against the shadow table and updates the flow's entry if allowed.
  function automatic bit rate_decision(input logic [pfwl_pkg::FlowW-1:0] flow,
                                       input logic [pfwl_pkg::TicksW-1:0] ticks);
    int unsigned idx;
    logic [pfwl_pkg::TicksW-1:0] elapsed;
    idx = flow % NumFlows;
    if (!flow_live[idx]) begin
      flow_live[idx]  = 1'b1;
      flow_count[idx] = CountBits'(1);
      flow_start[idx] = ticks;
      return 1'b1;
    end
    elapsed = ticks - flow_start[idx];
    if (elapsed >= lim_win) begin
      flow_count[idx] = CountBits'(1);
      flow_start[idx] = ticks;
      return 1'b1;
    end
    if (flow_count[idx] < lim_max && flow_count[idx] < CountTop) begin
      flow_count[idx] = flow_count[idx] + 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offers one request word and waits until it is taken. Valid is left high so
  // that a following word can go out back to back.
  task automatic offer_request(input logic [pfwl_pkg::FlowW-1:0] flow,
                               input logic [pfwl_pkg::TicksW-1:0] ticks,
                               input bit typed, input bit typed_verdict);
    bit verdict;
    in_valid_i  <= 1'b1;
    flow_id_i   <= flow;
    now_ticks_i <= ticks;
    do @(posedge clk_i); while (!in_ready_o);
    verdict = rate_decision(flow, ticks);
    pending_verdicts.push_back(typed ? typed_verdict : verdict);
    n_sent++;
  endtask

  // Registers change only once every outstanding verdict has come back.
  task automatic drain_and_configure(input logic [pfwl_pkg::MaxReqW-1:0] max_req,
                                     input logic [pfwl_pkg::TicksW-1:0] win);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pfwl_pkg::RegMaxRequests;
    cfg_data_i <= pfwl_pkg::CfgDataW'(max_req);
    @(posedge clk_i);
    cfg_idx_i  <= pfwl_pkg::RegWindowLength;
    cfg_data_i <= win;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_max = max_req;
    lim_win = win;
    n_settings++;
  endtask

  // Result side: checks each word taken and drives ready with random stalls and a requested hold.
  always @(posedge clk_i) begin
    cyc++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked++;
      if (!allowed_o) n_blocked++;
      if (pending_verdicts.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("verdict %0b arrived with no request pending", allowed_o);
      end else if (pending_verdicts[0] !== allowed_o) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("verdict mismatch on result %0d: expected %0b, got %0b",
                   n_checked, pending_verdicts[0], allowed_o);
        end
        void'(pending_verdicts.pop_front());
      end else begin
        void'(pending_verdicts.pop_front());
      end
    end
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet && cyc[6] && $urandom_range(0, 99) < 25) begin
      stall_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == StallLimit) begin
      $display("stalled with %0d verdicts outstanding", pending_verdicts.size());
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [pfwl_pkg::FlowW-1:0]   hot_flows [4];
    logic [pfwl_pkg::FlowW-1:0]   flow;
    logic [pfwl_pkg::TicksW-1:0]  ticks;
    logic [pfwl_pkg::TicksW-1:0]  now_base;
    logic [pfwl_pkg::MaxReqW-1:0] new_max;
    logic [pfwl_pkg::TicksW-1:0]  new_win;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].max_req != lim_max || dir_rows[r].win != lim_win) begin
        drain_and_configure(dir_rows[r].max_req, dir_rows[r].win);
      end
      offer_request(dir_rows[r].flow, dir_rows[r].ticks, dir_rows[r].typed,
                    dir_rows[r].verdict);
    end

    // Random phases: a few hot flows with slowly advancing time hit their limits,
    // the rest is scattered flows and out-of-order timestamps.
    for (int p = 0; p < 7; p++) begin
      now_base = $urandom;
      case (p)
        0: begin new_max = 16'd3; new_win = 32'd20; end
        1: begin new_max = 16'd1; new_win = 32'd1; end
        2: begin new_max = 16'hFFFF; new_win = 32'hFFFF_FFFF; end
        3: begin new_max = 16'd0; new_win = 32'd0; end
        4: begin
          new_max = pfwl_pkg::MaxReqW'($urandom_range(1, 8));
          new_win = $urandom_range(4, 64);
        end
        5: begin
          new_max = pfwl_pkg::MaxReqW'($urandom_range(0, 65535));
          new_win = $urandom;
        end
        default: begin
          new_max  = 16'd2;
          new_win  = 32'd8;
          now_base = 32'hFFFF_FF80;
        end
      endcase
      drain_and_configure(new_max, new_win);
      quiet = (p == 6);
      foreach (hot_flows[h]) hot_flows[h] = pfwl_pkg::FlowW'($urandom_range(0, NumFlows - 1));
      for (int k = 0; k < PhaseItems; k++) begin
        if (p == 4 && k == 20) hold_req = 1'b1;
        if ($urandom_range(0, 99) < 85) begin
          flow     = hot_flows[$urandom_range(0, 3)];
          now_base = now_base + $urandom_range(0, 2);
          ticks    = now_base;
        end else begin
          flow  = pfwl_pkg::FlowW'($urandom_range(0, NumFlows - 1));
          ticks = $urandom_range(0, 1) ? $urandom : now_base - $urandom_range(0, 50);
        end
        offer_request(flow, ticks, 1'b0, 1'b0);
        if (!quiet && k[5] && $urandom_range(0, 99) < 25) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d requests over %0d register settings, %0d verdicts checked, %0d blocked",
             n_sent, n_settings, n_checked, n_blocked);
    $display("%0d mismatches", n_bad);
    if (n_bad == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pfwl_pkg.sv
rtl/pfwl_entry_ram.sv
rtl/per_flow_fixed_window_limiter.sv
bench/tb.sv
